FILE: rtl/qse_pkg.sv
// ----------------------------------------------------------------------------
// qse_pkg
// Shared types, widths and helpers of the quintic segment evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package qse_pkg;

    // internal width of coefficients and accumulators, in half-LSB units
    localparam int KW = 56;
    localparam int HORNER_STEPS = 5;

    typedef logic signed [KW-1:0] t_wide;

    typedef struct packed {
        logic signed [KW-1:0] k0;
        logic signed [KW-1:0] k1;
        logic signed [KW-1:0] k2;
        logic signed [KW-1:0] k3;
        logic signed [KW-1:0] k4;
        logic signed [KW-1:0] k5;
    } t_coefs;

    typedef struct packed {
        logic signed [KW-1:0] pos;
        logic signed [KW-1:0] slope;
        logic signed [KW-1:0] curv;
    } t_acc;

    localparam t_wide OUT_MAX = KW'(32'sh7FFF_FFFF);
    localparam t_wide OUT_MIN = KW'(32'sh8000_0000);

    // Terms added after the multiply in Horner step s (1..5). All three chains
    // start from pos = k5, slope = 0, curv = 0, so they share one step count.
    function automatic t_acc add_terms(t_coefs k, int s);
        t_acc a;
        a = '0;
        case (s)
            1: begin
                a.pos   = k.k4;
                a.slope = k.k5 * 5;
                a.curv  = '0;
            end
            2: begin
                a.pos   = k.k3;
                a.slope = k.k4 * 4;
                a.curv  = k.k5 * 20;
            end
            3: begin
                a.pos   = k.k2;
                a.slope = k.k3 * 3;
                a.curv  = k.k4 * 12;
            end
            4: begin
                a.pos   = k.k1;
                a.slope = k.k2 * 2;
                a.curv  = k.k3 * 6;
            end
            5: begin
                a.pos   = k.k0;
                a.slope = k.k1;
                a.curv  = k.k2 * 2;
            end
            default: a = '0;
        endcase
        return a;
    endfunction

    // half-LSB to LSB, round half up, saturate to 32 bits
    function automatic logic signed [31:0] to_out(t_wide h);
        t_wide v;
        v = (h + 1) >>> 1;
        if (v > OUT_MAX) begin
            v = OUT_MAX;
        end else if (v < OUT_MIN) begin
            v = OUT_MIN;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/qse_if.sv
// ----------------------------------------------------------------------------
// qse_if
// Request and result channels of the quintic segment evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

interface qse_in_if #(
    parameter int PH_W = 17
);
    logic                   valid;
    logic                   ready;
    logic signed [31:0]     start_pos;
    logic signed [31:0]     end_pos;
    logic signed [31:0]     start_slope;
    logic signed [31:0]     end_slope;
    logic signed [31:0]     start_curv;
    logic signed [31:0]     end_curv;
    logic        [PH_W-1:0] phase;

    modport source (
        output valid, start_pos, end_pos, start_slope, end_slope,
               start_curv, end_curv, phase,
        input  ready
    );
    modport sink (
        input  valid, start_pos, end_pos, start_slope, end_slope,
               start_curv, end_curv, phase,
        output ready
    );
endinterface

interface qse_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] coef0;
    logic signed [31:0] coef1;
    logic signed [31:0] coef2;
    logic signed [31:0] coef3;
    logic signed [31:0] coef4;
    logic signed [31:0] coef5;
    logic signed [31:0] pos_out;
    logic signed [31:0] slope_out;
    logic signed [31:0] curv_out;

    modport source (
        output valid, coef0, coef1, coef2, coef3, coef4, coef5,
               pos_out, slope_out, curv_out,
        input  ready
    );
    modport sink (
        input  valid, coef0, coef1, coef2, coef3, coef4, coef5,
               pos_out, slope_out, curv_out,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/qse_coef.sv
// ----------------------------------------------------------------------------
// qse_coef
// Four-stage solver for the six quintic coefficients in half-LSB units.
// ----------------------------------------------------------------------------
`default_nettype none

module qse_coef #(
    parameter int FRAC_BITS = 16,
    parameter int PH_W      = FRAC_BITS + 1
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire signed [31:0]       i_start_pos,
    input  wire signed [31:0]       i_end_pos,
    input  wire signed [31:0]       i_start_slope,
    input  wire signed [31:0]       i_end_slope,
    input  wire signed [31:0]       i_start_curv,
    input  wire signed [31:0]       i_end_curv,
    input  wire        [PH_W-1:0]   i_phase,
    output logic                    o_valid,
    output qse_pkg::t_coefs         o_coefs,
    output logic       [PH_W-1:0]   o_phase
);
    import qse_pkg::*;

    localparam logic [PH_W-1:0] PH_ONE = PH_W'(1) << FRAC_BITS;

    logic [3:0]      r_v;
    t_wide           r1_k0, r1_k1, r1_k2, r1_y1, r1_y2, r1_dc;
    t_wide           r2_k0, r2_k1, r2_k2, r2_y1, r2_y2, r2_k3;
    t_wide           r3_k0, r3_k1, r3_k2, r3_y1, r3_k3, r3_k4;
    t_coefs          r4_k;
    logic [PH_W-1:0] r_ph [4];

    t_wide n_k0, n_k1, n_k2;
    logic [PH_W-1:0] n_ph;

    always_comb begin
        n_k0 = KW'(i_start_pos) * 2;
        n_k1 = KW'(i_start_slope) * 2;
        n_k2 = KW'(i_start_curv);
        n_ph = (i_phase > PH_ONE) ? PH_ONE : i_phase;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_k0 <= n_k0;
            r1_k1 <= n_k1;
            r1_k2 <= n_k2;
            r1_y1 <= KW'(i_end_pos) * 2 - n_k0 - n_k1 - n_k2;
            r1_y2 <= KW'(i_end_slope) * 2 - n_k1 - n_k2 * 2;
            r1_dc <= KW'(i_end_curv) - n_k2;
            r_ph[0] <= n_ph;

            r2_k0 <= r1_k0;
            r2_k1 <= r1_k1;
            r2_k2 <= r1_k2;
            r2_y1 <= r1_y1;
            r2_y2 <= r1_y2;
            r2_k3 <= r1_y1 * 10 - r1_y2 * 4 + r1_dc;
            r_ph[1] <= r_ph[0];

            r3_k0 <= r2_k0;
            r3_k1 <= r2_k1;
            r3_k2 <= r2_k2;
            r3_y1 <= r2_y1;
            r3_k3 <= r2_k3;
            r3_k4 <= r2_y1 * 5 - r2_y2 - r2_k3 * 2;
            r_ph[2] <= r_ph[1];

            r4_k.k0 <= r3_k0;
            r4_k.k1 <= r3_k1;
            r4_k.k2 <= r3_k2;
            r4_k.k3 <= r3_k3;
            r4_k.k4 <= r3_k4;
            r4_k.k5 <= r3_y1 - r3_k4 - r3_k3;
            r_ph[3] <= r_ph[2];
        end
    end

    assign o_valid = r_v[3];
    assign o_coefs = r4_k;
    assign o_phase = r_ph[3];

endmodule

`default_nettype wire

FILE: rtl/qse_horner_step.sv
// ----------------------------------------------------------------------------
// qse_horner_step
// One registered Horner step of the position, slope and curvature chains.
// ----------------------------------------------------------------------------
`default_nettype none

module qse_horner_step #(
    parameter int FRAC_BITS = 16,
    parameter int PH_W      = FRAC_BITS + 1,
    parameter int STEP      = 1
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire qse_pkg::t_coefs    i_coefs,
    input  wire qse_pkg::t_acc      i_acc,
    input  wire        [PH_W-1:0]   i_phase,
    output logic                    o_valid,
    output qse_pkg::t_coefs         o_coefs,
    output qse_pkg::t_acc           o_acc,
    output logic       [PH_W-1:0]   o_phase
);
    import qse_pkg::*;

    // the product is split in two halves to keep each multiplier narrow
    localparam int S  = KW / 2;
    localparam int HW = KW - S;
    localparam int PW = KW + PH_W + 1;

    // round(a * p / 2^FRAC_BITS), ties up
    function automatic t_wide mul_phase(t_wide a, logic [PH_W-1:0] p);
        logic signed [HW-1:0]   ah;
        logic        [S-1:0]    al;
        logic signed [HW+PH_W:0] hp;
        logic        [S+PH_W-1:0] lp;
        logic signed [PW-1:0]   sum;
        ah  = a[KW-1:S];
        al  = a[S-1:0];
        hp  = ah * $signed({1'b0, p});
        lp  = al * p;
        sum = (PW'(hp) <<< S) + $signed(PW'(lp)) + (PW'(1) <<< (FRAC_BITS - 1));
        return KW'(sum >>> FRAC_BITS);
    endfunction

    t_acc r_acc, n_acc, add;
    t_coefs r_k;
    logic [PH_W-1:0] r_ph;
    logic r_v;

    always_comb begin
        add         = add_terms(i_coefs, STEP);
        n_acc.pos   = mul_phase(i_acc.pos, i_phase) + add.pos;
        n_acc.slope = mul_phase(i_acc.slope, i_phase) + add.slope;
        n_acc.curv  = mul_phase(i_acc.curv, i_phase) + add.curv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
            r_k   <= i_coefs;
            r_ph  <= i_phase;
        end
    end

    assign o_valid = r_v;
    assign o_coefs = r_k;
    assign o_acc   = r_acc;
    assign o_phase = r_ph;

endmodule

`default_nettype wire

FILE: rtl/qse_out.sv
// ----------------------------------------------------------------------------
// qse_out
// Output register: rounds half-LSB values to Q16.16 and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module qse_out (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  wire qse_pkg::t_coefs i_coefs,
    input  wire qse_pkg::t_acc   i_acc,
    qse_out_if.source            o_res
);
    import qse_pkg::*;

    logic r_v;
    logic signed [31:0] r_c0, r_c1, r_c2, r_c3, r_c4, r_c5, r_pos, r_slope, r_curv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c0    <= to_out(i_coefs.k0);
            r_c1    <= to_out(i_coefs.k1);
            r_c2    <= to_out(i_coefs.k2);
            r_c3    <= to_out(i_coefs.k3);
            r_c4    <= to_out(i_coefs.k4);
            r_c5    <= to_out(i_coefs.k5);
            r_pos   <= to_out(i_acc.pos);
            r_slope <= to_out(i_acc.slope);
            r_curv  <= to_out(i_acc.curv);
        end
    end

    assign o_res.valid     = r_v;
    assign o_res.coef0     = r_c0;
    assign o_res.coef1     = r_c1;
    assign o_res.coef2     = r_c2;
    assign o_res.coef3     = r_c3;
    assign o_res.coef4     = r_c4;
    assign o_res.coef5     = r_c5;
    assign o_res.pos_out   = r_pos;
    assign o_res.slope_out = r_slope;
    assign o_res.curv_out  = r_curv;

endmodule

`default_nettype wire

FILE: rtl/quintic_segment_eval.sv
// ----------------------------------------------------------------------------
// quintic_segment_eval
// Quintic Hermite segment solver and evaluator, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one request per cycle while the result side does not stall and
// returns one result per request, in order. Four stages solve the
// coefficients, five stages run one Horner step each of the position, slope
// and curvature chains (every step holds six 28x17 multiplier halves), and
// one stage rounds and saturates into the output register. The whole
// pipeline advances together; while a result waits, requests stop.
`default_nettype none

module quintic_segment_eval #(
    parameter int FRAC_BITS = 16
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    qse_in_if.sink    i_seg,
    qse_out_if.source o_res
);
    import qse_pkg::*;

    localparam int PH_W = FRAC_BITS + 1;

    logic            en;
    logic            v_s  [HORNER_STEPS+1];
    t_coefs          k_s  [HORNER_STEPS+1];
    t_acc            a_s  [HORNER_STEPS+1];
    logic [PH_W-1:0] ph_s [HORNER_STEPS+1];

    assign en          = !o_res.valid || o_res.ready;
    assign i_seg.ready = en;

    qse_coef #(
        .FRAC_BITS (FRAC_BITS),
        .PH_W      (PH_W)
    ) u_coef (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_seg.valid),
        .i_start_pos   (i_seg.start_pos),
        .i_end_pos     (i_seg.end_pos),
        .i_start_slope (i_seg.start_slope),
        .i_end_slope   (i_seg.end_slope),
        .i_start_curv  (i_seg.start_curv),
        .i_end_curv    (i_seg.end_curv),
        .i_phase       (i_seg.phase),
        .o_valid       (v_s[0]),
        .o_coefs       (k_s[0]),
        .o_phase       (ph_s[0])
    );

    always_comb begin
        a_s[0].pos   = k_s[0].k5;
        a_s[0].slope = '0;
        a_s[0].curv  = '0;
    end

    for (genvar g = 0; g < HORNER_STEPS; g++) begin : g_step
        qse_horner_step #(
            .FRAC_BITS (FRAC_BITS),
            .PH_W      (PH_W),
            .STEP      (g + 1)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (v_s[g]),
            .i_coefs (k_s[g]),
            .i_acc   (a_s[g]),
            .i_phase (ph_s[g]),
            .o_valid (v_s[g+1]),
            .o_coefs (k_s[g+1]),
            .o_acc   (a_s[g+1]),
            .o_phase (ph_s[g+1])
        );
    end

    qse_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (v_s[HORNER_STEPS]),
        .i_coefs (k_s[HORNER_STEPS]),
        .i_acc   (a_s[HORNER_STEPS]),
        .o_res   (o_res)
    );

    // a stalled result must hold back new requests
    a_stall_blocks_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_seg.ready
    ) else $error("request taken while result stalled");

    // reset empties the pipeline
    a_reset_empties: assert property (
        @(posedge i_clk) !i_rst_n |=> !o_res.valid
    ) else $error("result valid right after reset");

    // while stalled the pipeline contents stay put
    a_stall_holds_stage: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(v_s[HORNER_STEPS]) && $stable(a_s[HORNER_STEPS])
    ) else $error("pipeline moved during stall");

endmodule

`default_nettype wire

FILE: verif/quintic_segment_eval_tb.sv
// ----------------------------------------------------------------------------
// quintic_segment_eval_tb
// Self-checking bench for the quintic segment evaluator.
// ----------------------------------------------------------------------------
// A table of directed segment requests (extremes, phase clamp, odd start
// curvature, coefficient overflow) runs first, then random requests. Every
// result is compared field by field against hand-set values (some directed
// rows) or an in-bench model of the coefficient solve and the three Horner
// chains. Both channels idle at random, except in the last part of the run.
`default_nettype none

module quintic_segment_eval_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int N_RANDOM = 730;
    localparam int CALM_TAIL = 100;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] p0, p1, s0, s1, c0, c1;
        logic [16:0]        ph;
    } t_seg;

    typedef struct {
        logic signed [31:0] f [9];
    } t_res;

    typedef struct {
        t_seg seg;
        bit   has_exp;
        t_res exp_res;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    qse_in_if  #(.PH_W(17)) seg_if ();
    qse_out_if              res_if ();

    quintic_segment_eval #(.FRAC_BITS(FRAC)) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg_if.sink),
        .o_res  (res_if.source)
    );

    t_res   pending_results[$];
    int     n_errors;
    int     n_checked;
    longint n_cycles;
    bit     calm;
    bit     inputs_done;
    t_row   rows[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---- prediction ----
    function automatic longint floor_shift(longint x, int k);
        return x >>> k;
    endfunction

    function automatic longint mul_ph(longint a, longint p);
        longint hi, lo;
        hi = floor_shift(a, FRAC);
        lo = a - hi * (longint'(1) << FRAC);
        return hi * p + ((lo * p + (longint'(1) << (FRAC - 1))) >>> FRAC);
    endfunction

    function automatic logic signed [31:0] half_to_q(longint h);
        longint v;
        v = floor_shift(h + 1, 1);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic t_res eval_segment(t_seg s);
        t_res   r;
        longint k[6];
        longint y1, y2, ph, acc;
        ph = (s.ph > 17'(1 << FRAC)) ? (longint'(1) << FRAC) : longint'(s.ph);
        k[0] = 2 * longint'(s.p0);
        k[1] = 2 * longint'(s.s0);
        k[2] = longint'(s.c0);
        y1 = 2 * longint'(s.p1) - k[0] - k[1] - k[2];
        y2 = 2 * longint'(s.s1) - k[1] - 2 * k[2];
        k[3] = 10 * y1 - 4 * y2 + (longint'(s.c1) - longint'(s.c0));
        k[4] = 5 * y1 - y2 - 2 * k[3];
        k[5] = y1 - k[4] - k[3];
        for (int i = 0; i < 6; i++) r.f[i] = half_to_q(k[i]);
        acc = k[5];
        for (int i = 4; i >= 0; i--) acc = mul_ph(acc, ph) + k[i];
        r.f[6] = half_to_q(acc);
        acc = 5 * k[5];
        for (int i = 4; i >= 1; i--) acc = mul_ph(acc, ph) + i * k[i];
        r.f[7] = half_to_q(acc);
        acc = 20 * k[5];
        for (int i = 4; i >= 2; i--) acc = mul_ph(acc, ph) + i * (i - 1) * k[i];
        r.f[8] = half_to_q(acc);
        return r;
    endfunction

    task automatic report_mismatch(string what, int idx, logic [31:0] got,
                                   logic [31:0] want);
        n_errors++;
        $display("MISMATCH %s field %0d: got %h want %h", what, idx, got, want);
    endtask

    // ---- result side: stall bursts and checking ----
    initial begin
        int idle;
        res_if.ready <= 1'b0;
        idle = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                t_res got, want;
                got.f = '{res_if.coef0, res_if.coef1, res_if.coef2, res_if.coef3,
                          res_if.coef4, res_if.coef5, res_if.pos_out,
                          res_if.slope_out, res_if.curv_out};
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0, 0);
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    for (int i = 0; i < 9; i++)
                        if (got.f[i] !== want.f[i])
                            report_mismatch("result", i, got.f[i], want.f[i]);
                end
            end
            if (idle > 0) idle--;
            else if (!calm && $urandom_range(0, 5) == 0) idle = $urandom_range(1, 9);
            res_if.ready <= (idle == 0);
        end
    end

    // ---- request side ----
    task automatic send_segment(t_seg s, t_res exp_res);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            seg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        seg_if.valid       <= 1'b1;
        seg_if.start_pos   <= s.p0;
        seg_if.end_pos     <= s.p1;
        seg_if.start_slope <= s.s0;
        seg_if.end_slope   <= s.s1;
        seg_if.start_curv  <= s.c0;
        seg_if.end_curv    <= s.c1;
        seg_if.phase       <= s.ph;
        pending_results.push_back(exp_res);
        do @(posedge i_clk); while (!seg_if.ready);
    endtask

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return $signed(32'($urandom_range(0, 8191)) - 32'd4096);
            3: return $signed(32'($urandom_range(0, 2 << 20)) - 32'(1 << 20));
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic t_seg rand_seg();
        t_seg s;
        s.p0 = rand_val(); s.p1 = rand_val();
        s.s0 = rand_val(); s.s1 = rand_val();
        s.c0 = rand_val(); s.c1 = rand_val();
        case ($urandom_range(0, 7))
            0: s.ph = 17'd0;
            1: s.ph = 17'h10000;
            2: s.ph = 17'($urandom_range(17'h10001, 17'h1FFFF));
            default: s.ph = 17'($urandom_range(0, 17'h10000));
        endcase
        return s;
    endfunction

    function automatic t_row mk(logic [31:0] p0, logic [31:0] p1, logic [31:0] s0,
                                logic [31:0] s1, logic [31:0] c0, logic [31:0] c1,
                                logic [16:0] ph);
        t_row r;
        r.seg = '{p0, p1, s0, s1, c0, c1, ph};
        r.has_exp = 1'b0;
        return r;
    endfunction

    function automatic t_row mk_exp(t_row r, logic [31:0] v [9]);
        r.has_exp = 1'b1;
        for (int i = 0; i < 9; i++) r.exp_res.f[i] = v[i];
        return r;
    endfunction

    initial begin
        t_row  row;
        t_res  e;
        seg_if.valid <= 1'b0;
        seg_if.start_pos <= '0; seg_if.end_pos <= '0;
        seg_if.start_slope <= '0; seg_if.end_slope <= '0;
        seg_if.start_curv <= '0; seg_if.end_curv <= '0;
        seg_if.phase <= '0;
        i_rst_n <= 1'b0;
        n_errors = 0; n_checked = 0; calm = 0; inputs_done = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all zero and constant segments: read off directly
        rows.push_back(mk_exp(mk(0, 0, 0, 0, 0, 0, 17'h08000),
                              '{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        rows.push_back(mk_exp(mk(32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0, 17'h1FFFF),
                              '{32'h0001_0000, 0, 0, 0, 0, 0, 32'h0001_0000, 0, 0}));
        // odd start curvature rounds coef2 half up
        rows.push_back(mk_exp(mk(0, 0, 0, 0, 1, 1, 0),
                              '{0, 0, 1, 32'hFFFF_FFFF, 1, 0, 0, 0, 1}));
        rows.push_back(mk_exp(mk(0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0),
                              '{0, 0, 0, 1, 0, 0, 0, 0, 32'hFFFF_FFFF}));
        // large position jump saturates the high coefficients
        rows.push_back(mk(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 17'h10000));
        rows.push_back(mk(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 17'h04000));
        rows.push_back(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 17'h1FFFF));
        rows.push_back(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 17'h10001));
        rows.push_back(mk(0, 32'h0001_0000, 0, 0, 0, 0, 17'h08000));
        rows.push_back(mk(0, 0, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 17'h0C000));
        rows.push_back(mk(0, 0, 0, 0, 32'h0002_0000, 32'hFFFE_0000, 17'h00001));
        rows.push_back(mk(32'hFFFF_FFFF, 1, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'h0F0F_0F0F, 32'hF0F0_F0F0, 17'h0FFFF));
        rows.push_back(mk(32'h1234_5678, 32'hEDCB_A987, 32'h0000_8000, 32'hFFFF_8000,
                          32'h0000_0003, 32'hFFFF_FFFD, 17'h15555));

        foreach (rows[i]) begin
            row = rows[i];
            e = row.has_exp ? row.exp_res : eval_segment(row.seg);
            send_segment(row.seg, e);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            t_seg s;
            if (n == N_RANDOM - CALM_TAIL) calm = 1;
            s = rand_seg();
            send_segment(s, eval_segment(s));
        end
        seg_if.valid <= 1'b0;
        inputs_done = 1;
    end

    // ---- end of run and watchdog ----
    initial begin
        n_cycles = 0;
        while (!(inputs_done && pending_results.size() == 0)) begin
            @(posedge i_clk);
            n_cycles++;
            if (n_cycles > CYCLE_LIMIT) begin
                $display("timeout with %0d results outstanding", pending_results.size());
                $display("FAILED: results differ");
                $finish;
            end
        end
        repeat (30) @(posedge i_clk);
        $display("Checked %0d segment results (%0d directed rows, random rest),",
                 n_checked, rows.size());
        $display("covering saturation, phase clamp and channel stalls; %0d errors.",
                 n_errors);
        if (n_errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/qse_pkg.sv
rtl/qse_if.sv
rtl/qse_coef.sv
rtl/qse_horner_step.sv
rtl/qse_out.sv
rtl/quintic_segment_eval.sv
verif/quintic_segment_eval_tb.sv
